@@ sv/gstr_pkg.sv @@
`default_nettype none

package gstr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 24;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = DIFF_W + SAMPLE_W;
  localparam int ERR_W      = 33;
  localparam int GSUM_W     = GAIN_W + 1;
  localparam int STEP_W     = ERR_W + GSUM_W;
  localparam int ACC_W      = STEP_W + 1;
  localparam int PHASE_FRAC = 48;
  localparam int PHASE_W    = PHASE_FRAC + 1;
  localparam int OUT_OFF_W  = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic signed [ACC_W-1:0] PHASE_ONE =
    {{(ACC_W-PHASE_FRAC-1){1'b0}}, 1'b1, {PHASE_FRAC{1'b0}}};
  localparam logic signed [ACC_W-1:0] PHASE_MASK = PHASE_ONE - ACC_W'(1);

  localparam logic REG_GAIN_P = 1'b0;
  localparam logic REG_GAIN_I = 1'b1;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = -24'sd2925;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = -24'sd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } sample_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gp;
    logic signed [GAIN_W-1:0] gi;
  } gains_t;

  typedef struct packed {
    logic cap_early;
    logic cap_mid;
    logic mul;
    logic err;
    logic step;
    logic add;
    logic wrap_hi;
    logic wrap_lo;
    logic offs;
  } loop_ctrl_t;

endpackage

`default_nettype wire

@@ sv/gardner_symbol_timing_recovery.sv @@
// Gardner symbol timing recovery with a proportional-plus-integral loop.
// Input channel: one complex sample word (sample_i_i, sample_q_i) per accepted
// in_valid_i/in_ready_o handshake, at SAMPLES_PER_SYMBOL samples per symbol.
// Output channel: one symbol word (symbol_i_o, symbol_q_o, timing_offset_o) per
// out_valid_o/out_ready_i handshake, after the first 2*SPS+1 samples and then
// once every SPS samples.
// Throughput: samples are taken one per cycle. The sample that completes a
// symbol starts a decision during which in_ready_o is low and no sample is taken.
// Its length is set by the single read port of the sample ring (early, mid, late
// and output reads in turn) and by the loop datapath, which runs multiply, gain,
// phase add, wrap and rounding one register stage per state. The decision runs
// RD_E, RD_M, RD_L, MUL, ERR, STEP, ADD, WRAP_HI, WRAP_LO, OFFS, RD_S and EMIT;
// out_valid_o rises as EMIT loads the output register.
// Stall: the result waits in an output register; samples are still taken while
// it waits, but the next decision holds in EMIT until it is taken.
// Reset clears the counters, phase, offset and gains (to their defaults); the
// ring holds no valid data until written and needs no clearing pass. The user
// writes gains over the APB port only while the block is idle; no logic checks it.
`default_nettype none

module gardner_symbol_timing_recovery #(
  parameter int SAMPLES_PER_SYMBOL = 10
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire signed [gstr_pkg::SAMPLE_W-1:0]    sample_i_i,
  input  wire signed [gstr_pkg::SAMPLE_W-1:0]    sample_q_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [gstr_pkg::SAMPLE_W-1:0]   symbol_i_o,
  output logic signed [gstr_pkg::SAMPLE_W-1:0]   symbol_q_o,
  output logic [gstr_pkg::OUT_OFF_W-1:0]         timing_offset_o,
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire [gstr_pkg::APB_ADDR_W-1:0]         paddr,
  input  wire [gstr_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [gstr_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int SPS    = SAMPLES_PER_SYMBOL;
  localparam int DEPTH  = 2 * SPS + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int OFFW   = $clog2(SPS + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OFFX_W = (OFFW > gstr_pkg::OUT_OFF_W) ? OFFW : gstr_pkg::OUT_OFF_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_E,
    ST_RD_M,
    ST_RD_L,
    ST_MUL,
    ST_ERR,
    ST_STEP,
    ST_ADD,
    ST_WRAP_HI,
    ST_WRAP_LO,
    ST_OFFS,
    ST_RD_S,
    ST_EMIT
  } state_e;

  state_e                           state_q, state_d;
  logic [AW-1:0]                    ptr_q, ptr_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             full_q, full_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [gstr_pkg::SAMPLE_W-1:0] sym_i_q, sym_i_d;
  logic signed [gstr_pkg::SAMPLE_W-1:0] sym_q_q, sym_q_d;
  logic [gstr_pkg::OUT_OFF_W-1:0]   toff_q, toff_d;

  gstr_pkg::loop_ctrl_t             ctrl;
  gstr_pkg::gains_t                 gains;
  gstr_pkg::sample_t                wdata, rdata;
  logic                             in_acc, ring_re, out_free, decide;
  logic [AW-1:0]                    j_sel, raddr;
  logic [AW:0]                      asum;
  logic [CNT_W-1:0]                 cnt_inc;
  logic [OFFW-1:0]                  offset;
  logic [OFFX_W-1:0]                offset_x;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign decide     = full_q ? (cnt_inc == CNT_W'(SPS)) : (cnt_inc == CNT_W'(DEPTH));
  assign wdata.i    = sample_i_i;
  assign wdata.q    = sample_q_i;
  assign offset_x   = OFFX_W'(offset);

  // Window entry j (0 oldest) sits j+1 places past the newest sample in ring order.
  assign asum  = (AW+1)'(ptr_q) + (AW+1)'(1) + (AW+1)'(j_sel);
  assign raddr = (asum >= (AW+1)'(DEPTH)) ? AW'(asum - (AW+1)'(DEPTH)) : AW'(asum);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sym_i_d     = sym_i_q;
    sym_q_d     = sym_q_q;
    toff_d      = toff_q;
    ctrl        = '0;
    ring_re     = 1'b0;
    j_sel       = AW'(offset);
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ptr_d = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
          if (decide) begin
            cnt_d   = '0;
            full_d  = 1'b1;
            state_d = ST_RD_E;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      ST_RD_E: begin
        ring_re = 1'b1;
        state_d = ST_RD_M;
      end
      ST_RD_M: begin
        ring_re        = 1'b1;
        j_sel          = AW'(offset) + AW'(SPS / 2);
        ctrl.cap_early = 1'b1;
        state_d        = ST_RD_L;
      end
      ST_RD_L: begin
        ring_re      = 1'b1;
        j_sel        = AW'(offset) + AW'(SPS);
        ctrl.cap_mid = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul = 1'b1;
        state_d  = ST_ERR;
      end
      ST_ERR: begin
        ctrl.err = 1'b1;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        ctrl.step = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        ctrl.add = 1'b1;
        state_d  = ST_WRAP_HI;
      end
      ST_WRAP_HI: begin
        ctrl.wrap_hi = 1'b1;
        state_d      = ST_WRAP_LO;
      end
      ST_WRAP_LO: begin
        ctrl.wrap_lo = 1'b1;
        state_d      = ST_OFFS;
      end
      ST_OFFS: begin
        ctrl.offs = 1'b1;
        state_d   = ST_RD_S;
      end
      ST_RD_S: begin
        ring_re = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sym_i_d     = rdata.i;
          sym_q_d     = rdata.q;
          toff_d      = offset_x[gstr_pkg::OUT_OFF_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sym_i_q     <= '0;
      sym_q_q     <= '0;
      toff_q      <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      sym_i_q     <= sym_i_d;
      sym_q_q     <= sym_q_d;
      toff_q      <= toff_d;
    end
  end

  gstr_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(ptr_d),
    .wdata_i(wdata),
    .re_i   (ring_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  gstr_loop #(
    .SPS(SPS)
  ) u_loop (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .rdata_i (rdata),
    .gains_i (gains),
    .offset_o(offset)
  );

  gstr_apb u_apb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .gains_o(gains)
  );

  assign out_valid_o     = out_valid_q;
  assign symbol_i_o      = sym_i_q;
  assign symbol_q_o      = sym_q_q;
  assign timing_offset_o = toff_q;

endmodule

`default_nettype wire

@@ sv/gstr_ring.sv @@
`default_nettype none

module gstr_ring #(
  parameter int DEPTH = 21
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  gstr_pkg::sample_t        wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output gstr_pkg::sample_t        rdata_o
);

  gstr_pkg::sample_t mem_q [DEPTH];
  gstr_pkg::sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/gstr_apb.sv @@
`default_nettype none

module gstr_apb (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [gstr_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire [gstr_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [gstr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output gstr_pkg::gains_t                     gains_o
);

  logic signed [gstr_pkg::GAIN_W-1:0] gp_q, gp_d;
  logic signed [gstr_pkg::GAIN_W-1:0] gi_q, gi_d;
  logic                               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    gp_d = gp_q;
    gi_d = gi_q;
    if (wr_en) begin
      unique case (paddr[2])
        gstr_pkg::REG_GAIN_P: gp_d = pwdata[gstr_pkg::GAIN_W-1:0];
        gstr_pkg::REG_GAIN_I: gi_d = pwdata[gstr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q <= gstr_pkg::GAIN_P_RESET;
      gi_q <= gstr_pkg::GAIN_I_RESET;
    end else begin
      gp_q <= gp_d;
      gi_q <= gi_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      gstr_pkg::REG_GAIN_P: prdata = gstr_pkg::APB_DATA_W'(gp_q);
      gstr_pkg::REG_GAIN_I: prdata = gstr_pkg::APB_DATA_W'(gi_q);
      default:              prdata = '0;
    endcase
  end

  assign gains_o.gp = gp_q;
  assign gains_o.gi = gi_q;

endmodule

`default_nettype wire

@@ sv/gstr_loop.sv @@
`default_nettype none

module gstr_loop #(
  parameter int SPS = 10
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  gstr_pkg::loop_ctrl_t             ctrl_i,
  input  gstr_pkg::sample_t                rdata_i,
  input  gstr_pkg::gains_t                 gains_i,
  output logic [$clog2(SPS+1)-1:0]         offset_o
);

  localparam int OFFW    = $clog2(SPS + 1);
  localparam int SCALE_W = gstr_pkg::PHASE_W + OFFW + 1;
  localparam int N_W     = SCALE_W - gstr_pkg::PHASE_FRAC;
  localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1) << (gstr_pkg::PHASE_FRAC - 1);
  localparam logic [SCALE_W-1:0] SPS_S      = SCALE_W'(SPS);
  localparam logic [N_W-1:0]     SPS_N      = N_W'(SPS);

  gstr_pkg::sample_t                          early_q, mid_q;
  logic signed [gstr_pkg::PROD_W-1:0]         prod_i_q, prod_q_q;
  logic signed [gstr_pkg::ERR_W-1:0]          err_q;
  logic signed [gstr_pkg::GSUM_W-1:0]         gsum_q;
  logic signed [gstr_pkg::STEP_W-1:0]         step_q;
  logic signed [gstr_pkg::ACC_W-1:0]          acc_q;
  logic [gstr_pkg::PHASE_W-1:0]               phase_q;
  logic [OFFW-1:0]                            offset_q;

  logic signed [gstr_pkg::DIFF_W-1:0]         diff_i, diff_q;
  logic signed [gstr_pkg::ACC_W-1:0]          acc_phase;
  logic signed [gstr_pkg::ACC_W-1:0]          acc_lo;
  logic [SCALE_W-1:0]                         scaled;
  logic [N_W-1:0]                             n_raw;

  assign diff_i    = gstr_pkg::DIFF_W'(early_q.i) - gstr_pkg::DIFF_W'(rdata_i.i);
  assign diff_q    = gstr_pkg::DIFF_W'(early_q.q) - gstr_pkg::DIFF_W'(rdata_i.q);
  assign acc_phase = $signed({{(gstr_pkg::ACC_W-gstr_pkg::PHASE_W){1'b0}}, phase_q});

  always_comb begin
    acc_lo = acc_q;
    if (acc_lo < 0) begin
      acc_lo = acc_lo + gstr_pkg::PHASE_ONE;
    end
    if (acc_lo < 0 || acc_lo > gstr_pkg::PHASE_ONE) begin
      acc_lo = acc_lo & gstr_pkg::PHASE_MASK;
    end
  end

  assign scaled = SCALE_W'(phase_q) * SPS_S + ROUND_HALF;
  assign n_raw  = scaled[SCALE_W-1:gstr_pkg::PHASE_FRAC];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_early) begin
      early_q <= rdata_i;
    end
    if (ctrl_i.cap_mid) begin
      mid_q <= rdata_i;
    end
    if (ctrl_i.mul) begin
      prod_i_q <= diff_i * mid_q.i;
      prod_q_q <= diff_q * mid_q.q;
    end
    if (ctrl_i.err) begin
      err_q  <= gstr_pkg::ERR_W'(prod_i_q + prod_q_q);
      gsum_q <= gstr_pkg::GSUM_W'(gains_i.gp) + gstr_pkg::GSUM_W'(gains_i.gi);
    end
    if (ctrl_i.step) begin
      step_q <= err_q * gsum_q;
    end
    if (ctrl_i.add) begin
      acc_q <= acc_phase + gstr_pkg::ACC_W'(step_q);
    end else if (ctrl_i.wrap_hi) begin
      if (acc_q > gstr_pkg::PHASE_ONE) begin
        acc_q <= acc_q - gstr_pkg::PHASE_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      offset_q <= '0;
    end else begin
      if (ctrl_i.wrap_lo) begin
        phase_q <= acc_lo[gstr_pkg::PHASE_W-1:0];
      end
      if (ctrl_i.offs) begin
        offset_q <= (n_raw > SPS_N) ? OFFW'(SPS) : OFFW'(n_raw);
      end
    end
  end

  assign offset_o = offset_q;

endmodule

`default_nettype wire

@@ sv/gstr_checker.sv @@
`default_nettype none

module gstr_checker #(
  parameter int SPS = 10
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_ready_o,
  input wire                               out_valid_o,
  input wire                               out_ready_i,
  input wire [gstr_pkg::SAMPLE_W-1:0]      symbol_i_o,
  input wire [gstr_pkg::SAMPLE_W-1:0]      symbol_q_o,
  input wire [gstr_pkg::OUT_OFF_W-1:0]     timing_offset_o
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_i_o) &&
      $stable(symbol_q_o) && $stable(timing_offset_o))
    else $error("stalled result word changed");

  // A new result only appears from the decision sequence, when no sample was taken.
  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while samples were being taken");

  // The reported offset never exceeds one symbol.
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(timing_offset_o) <= SPS))
    else $error("timing offset beyond one symbol");

  // After a new result word, the block is back to taking samples.
  a_ready_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("sample input not reopened after result");

endmodule

bind gardner_symbol_timing_recovery gstr_checker #(
  .SPS(SAMPLES_PER_SYMBOL)
) u_gstr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .symbol_i_o     (symbol_i_o),
  .symbol_q_o     (symbol_q_o),
  .timing_offset_o(timing_offset_o)
);

`default_nettype wire
